### hw/rtl/lbc_pkg.sv
`timescale 1ns / 1ps
package lbc_pkg;

  typedef logic signed [15:0] q14_t;

  // Configuration register indexes.
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_RELAX      = 3'd0;
  localparam cfg_idx_t CFG_EDGE_RELAX = 3'd1;
  localparam cfg_idx_t CFG_EDGE_RHO   = 3'd2;
  localparam cfg_idx_t CFG_EDGE_UX    = 3'd3;
  localparam cfg_idx_t CFG_EDGE_UY    = 3'd4;

  localparam int NDIR = 9;

  // Lattice directions: rest, E, N, W, S, NE, NW, SW, SE.
  localparam int DIR_EX  [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_EY  [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int DIR_INV [NDIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
  localparam int DIR_W36 [NDIR] = '{16, 4, 4, 4, 4, 1, 1, 1, 1};

  // Quotient bits of the velocity divider and its latency.
  localparam int DIV_QBITS = 17;
  localparam int DIV_LAT   = DIV_QBITS + 1;

  // Pipeline depth of one direction lane.
  localparam int LANE_LAT = 10;

  // Data that travels beside the divider.
  typedef struct packed {
    logic [8:0]       mask;
    logic             at_edge;
    logic             neg_x;
    logic             neg_y;
    logic             zero_rho;
    logic [15:0]      rho;
    logic [8:0][15:0] dirs;
  } side_t;

  // One finished result.
  typedef struct packed {
    logic [8:0][15:0] dirs;
    logic [15:0]      rho;
    logic [15:0]      ux;
    logic [15:0]      uy;
  } res_t;

endpackage

### hw/rtl/lbc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: quo = floor(num * 2^14 / den), one quotient bit per stage.
// The overflow flag is set when the quotient does not fit in DIV_QBITS bits.
module lbc_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [17:0]                   num_i,
  input  logic [18:0]                   den_i,
  output logic [lbc_pkg::DIV_QBITS-1:0] quo_o,
  output logic                          ovf_o
);
  import lbc_pkg::*;

  logic [31:0]          rem_r [0:DIV_QBITS];
  logic [DIV_QBITS-1:0] quo_r [0:DIV_QBITS];
  logic [18:0]          den_r [0:DIV_QBITS];
  logic                 ovf_r [0:DIV_QBITS];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {num_i, 14'b0};
      quo_r[0] <= '0;
      den_r[0] <= den_i;
      ovf_r[0] <= ({4'b0, num_i} >= {den_i, 3'b0});
    end
  end

  for (genvar s = 0; s < DIV_QBITS; s++) begin : g_stage
    localparam int B = DIV_QBITS - 1 - s;
    logic [35:0]          dsh;
    logic [35:0]          diff;
    logic                 ge;
    logic [DIV_QBITS-1:0] q_nxt;

    always_comb begin
      dsh      = 36'(den_r[s]) << B;
      ge       = ({4'b0, rem_r[s]} >= dsh);
      diff     = {4'b0, rem_r[s]} - dsh;
      q_nxt    = quo_r[s];
      q_nxt[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= ge ? diff[31:0] : rem_r[s];
        quo_r[s+1] <= q_nxt;
        den_r[s+1] <= den_r[s];
        ovf_r[s+1] <= ovf_r[s];
      end
    end
  end

  assign quo_o = quo_r[DIV_QBITS];
  assign ovf_o = ovf_r[DIV_QBITS];
endmodule

### hw/rtl/lbc_lane.sv
`timescale 1ns / 1ps
// One direction: equilibrium, relaxation and saturation, ten register stages.
// usq_i must be presented while this lane's second stage holds the same cell.
module lbc_lane #(
  parameter int EX = 0,
  parameter int EY = 0,
  parameter int W  = 1
) (
  input  logic          clk,
  input  logic          en,
  input  lbc_pkg::q14_t f_i,
  input  lbc_pkg::q14_t rho_i,
  input  lbc_pkg::q14_t ux_i,
  input  lbc_pkg::q14_t uy_i,
  input  logic [14:0]   omega_i,
  input  logic [31:0]   usq_i,
  output lbc_pkg::q14_t post_o
);
  import lbc_pkg::*;

  localparam int                WSH     = $clog2(W);
  localparam logic [28:0]       RECIP9  = 29'd477218589;
  localparam logic signed [59:0] RND_OFS = (60'sd36 <<< 28) + (60'sd9 <<< 55);
  localparam logic signed [26:0] FEQ_OFS = 27'sd16777216;
  localparam logic signed [37:0] TWO_Q28 = 38'sd1 <<< 29;

  // Stage 1
  logic signed [17:0] eu1_r;
  q14_t               f1_r, rho1_r;
  logic [14:0]        om1_r;
  // Stage 2
  logic signed [35:0] eusq2_r;
  logic signed [17:0] eu2_r;
  q14_t               f2_r, rho2_r;
  logic [14:0]        om2_r;
  // Stage 3
  logic signed [37:0] p2_r;
  q14_t               f3_r, rho3_r;
  logic [14:0]        om3_r;
  // Stage 4
  logic signed [35:0] pplo_r;
  logic signed [34:0] pphi_r;
  q14_t               f4_r;
  logic [14:0]        om4_r;
  // Stage 5
  logic signed [55:0] prod_r;
  q14_t               f5_r;
  logic [14:0]        om5_r;
  // Stage 6
  logic [28:0]        u6_r;
  q14_t               f6_r;
  logic [14:0]        om6_r;
  // Stage 7
  logic [57:0]        mq7_r;
  q14_t               f7_r;
  logic [14:0]        om7_r;
  // Stage 8
  logic signed [26:0] diff8_r;
  q14_t               f8_r;
  logic [14:0]        om8_r;
  // Stage 9
  logic signed [42:0] rp9_r;
  q14_t               f9_r;
  // Stage 10
  q14_t               post_r;

  logic signed [17:0] tx, ty, eu_c;
  logic signed [37:0] usq38, eu38, eq38, p2_c;
  logic signed [19:0] lo20;
  logic signed [18:0] hi19;
  logic signed [59:0] v_c;
  logic signed [26:0] feq_c;
  logic signed [43:0] rr_c;
  logic signed [30:0] sum_c;

  always_comb begin
    tx = (EX > 0) ? 18'(ux_i) : ((EX < 0) ? -18'(ux_i) : 18'sd0);
    ty = (EY > 0) ? 18'(uy_i) : ((EY < 0) ? -18'(uy_i) : 18'sd0);
    eu_c = tx + ty;

    // Twice the bracket in Q.28: 2 - 3u.u + 6 e.u + 9 (e.u)^2.
    usq38 = $signed({6'b0, usq_i});
    eu38  = 38'(eu2_r);
    eq38  = 38'(eusq2_r);
    p2_c  = TWO_Q28 - (usq38 + (usq38 <<< 1)) + (eu38 <<< 15) + (eu38 <<< 16)
            + (eq38 <<< 3) + eq38;

    lo20 = $signed({1'b0, p2_r[18:0]});
    hi19 = p2_r[37:19];

    // Offset keeps the value positive so the divide by 9 works unsigned.
    v_c   = (60'(prod_r) <<< WSH) + RND_OFS;
    feq_c = $signed({1'b0, mq7_r[57:32]}) - FEQ_OFS;

    rr_c  = 44'(rp9_r) + 44'sd8192;
    sum_c = 31'($signed(rr_c[43:14])) + 31'(f9_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eu1_r   <= eu_c;
      f1_r    <= f_i;
      rho1_r  <= rho_i;
      om1_r   <= omega_i;

      eusq2_r <= eu1_r * eu1_r;
      eu2_r   <= eu1_r;
      f2_r    <= f1_r;
      rho2_r  <= rho1_r;
      om2_r   <= om1_r;

      p2_r    <= p2_c;
      f3_r    <= f2_r;
      rho3_r  <= rho2_r;
      om3_r   <= om2_r;

      pplo_r  <= rho3_r * lo20;
      pphi_r  <= rho3_r * hi19;
      f4_r    <= f3_r;
      om4_r   <= om3_r;

      prod_r  <= (56'(pphi_r) <<< 19) + 56'(pplo_r);
      f5_r    <= f4_r;
      om5_r   <= om4_r;

      u6_r    <= v_c[59:31];
      f6_r    <= f5_r;
      om6_r   <= om5_r;

      mq7_r   <= u6_r * RECIP9;
      f7_r    <= f6_r;
      om7_r   <= om6_r;

      diff8_r <= feq_c - 27'(f7_r);
      f8_r    <= f7_r;
      om8_r   <= om7_r;

      rp9_r   <= $signed({1'b0, om8_r}) * diff8_r;
      f9_r    <= f8_r;

      if (sum_c > 31'sd32767) begin
        post_r <= 16'sh7fff;
      end else if (sum_c < -31'sd32768) begin
        post_r <= 16'sh8000;
      end else begin
        post_r <= sum_c[15:0];
      end
    end
  end

  assign post_o = post_r;
endmodule

### hw/rtl/lbc_merge.sv
`timescale 1ns / 1ps
// Bounce-back remap of the lane results, output register and skid register.
module lbc_merge (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tail_valid,
  input  logic [8:0][15:0] post_i,
  input  logic [8:0]       mask_i,
  input  logic [15:0]      rho_i,
  input  logic [15:0]      ux_i,
  input  logic [15:0]      uy_i,
  input  logic             out_ready,
  output logic             en,
  output logic             out_valid,
  output lbc_pkg::res_t    res_o
);
  import lbc_pkg::*;

  res_t res_c, res_r, skid_r;
  logic out_valid_r, skid_full_r;

  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      res_c.dirs[k] = mask_i[DIR_INV[k]] ? post_i[DIR_INV[k]] : post_i[k];
    end
    res_c.rho = rho_i;
    res_c.ux  = ux_i;
    res_c.uy  = uy_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!skid_full_r) begin
      if (!out_valid_r || out_ready) begin
        out_valid_r <= tail_valid;
      end else if (tail_valid) begin
        skid_full_r <= 1'b1;
      end
    end else if (out_ready) begin
      skid_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full_r) begin
      if (!out_valid_r || out_ready) begin
        res_r <= res_c;
      end else begin
        skid_r <= res_c;
      end
    end else if (out_ready) begin
      res_r <= skid_r;
    end
  end

  assign en        = !skid_full_r;
  assign out_valid = out_valid_r;
  assign res_o     = res_r;
endmodule

### hw/rtl/lattice_boltzmann_cell_collision_core.sv
`timescale 1ns / 1ps
// D2Q9 BGK collision core, one lattice cell per transfer.
//
// Input channel (in_valid / in_ready): the nine distributions of a cell, its
// obstacle-neighbor mask and the edge and fluid flags. A transfer with
// in_cell_is_fluid low is taken and dropped; it produces no result.
// Output channel (out_valid / out_ready): nine post-collision values, already
// remapped for bounce-back, plus the density and velocity used for the cell.
// Configuration: a write on cfg_we loads register cfg_index from cfg_wdata.
// Write it only while no cell is in flight.
//
// Throughput is one cell per cycle while in_ready is high; the 18-stage velocity
// divider and the ten-stage direction lanes are fully pipelined, so nothing in
// the datapath iterates.
// When the receiver stalls, the finished result sits in the output register
// and the next one in a skid register; only then does in_ready drop and the
// whole pipeline hold. Synchronous reset empties the pipeline and loads the
// configuration defaults.
module lattice_boltzmann_cell_collision_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lbc_pkg::q14_t in_dist_rest,
  input  lbc_pkg::q14_t in_dist_east,
  input  lbc_pkg::q14_t in_dist_north,
  input  lbc_pkg::q14_t in_dist_west,
  input  lbc_pkg::q14_t in_dist_south,
  input  lbc_pkg::q14_t in_dist_northeast,
  input  lbc_pkg::q14_t in_dist_northwest,
  input  lbc_pkg::q14_t in_dist_southwest,
  input  lbc_pkg::q14_t in_dist_southeast,
  input  logic [8:0]    in_obstacle_mask,
  input  logic          in_at_edge,
  input  logic          in_cell_is_fluid,
  output logic          out_valid,
  input  logic          out_ready,
  output lbc_pkg::q14_t out_rest,
  output lbc_pkg::q14_t out_east,
  output lbc_pkg::q14_t out_north,
  output lbc_pkg::q14_t out_west,
  output lbc_pkg::q14_t out_south,
  output lbc_pkg::q14_t out_northeast,
  output lbc_pkg::q14_t out_northwest,
  output lbc_pkg::q14_t out_southwest,
  output lbc_pkg::q14_t out_southeast,
  output lbc_pkg::q14_t out_cell_density,
  output lbc_pkg::q14_t out_cell_velocity_x,
  output lbc_pkg::q14_t out_cell_velocity_y,
  input  logic          cfg_we,
  input  lbc_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]   cfg_wdata
);
  import lbc_pkg::*;

  logic en;

  // Configuration registers.
  logic [14:0] relax_r, edge_relax_r, edge_rho_r;
  logic [15:0] edge_ux_r, edge_uy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relax_r      <= 15'd31949;
      edge_relax_r <= 15'd16384;
      edge_rho_r   <= 15'd16384;
      edge_ux_r    <= 16'd819;
      edge_uy_r    <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RELAX:      relax_r      <= cfg_wdata[14:0];
        CFG_EDGE_RELAX: edge_relax_r <= cfg_wdata[14:0];
        CFG_EDGE_RHO:   edge_rho_r   <= cfg_wdata[14:0];
        CFG_EDGE_UX:    edge_ux_r    <= cfg_wdata;
        CFG_EDGE_UY:    edge_uy_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage 0: input register. Obstacle cells enter as bubbles.
  logic             v0_r;
  logic [8:0][15:0] f0_r;
  logic [8:0]       mask0_r;
  logic             edge0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid && in_cell_is_fluid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_r    <= {in_dist_southeast, in_dist_southwest, in_dist_northwest, in_dist_northeast,
                  in_dist_south, in_dist_west, in_dist_north, in_dist_east, in_dist_rest};
      mask0_r <= in_obstacle_mask;
      edge0_r <= in_at_edge;
    end
  end

  // Stage 1: density and momentum sums.
  logic               v1_r;
  logic [8:0][15:0]   f1_r;
  logic [8:0]         mask1_r;
  logic               edge1_r;
  logic signed [19:0] rsum1_r;
  logic signed [18:0] mx1_r, my1_r;
  logic signed [19:0] rsum_c;
  logic signed [18:0] mx_c, my_c;

  always_comb begin
    rsum_c = '0;
    for (int k = 0; k < NDIR; k++) begin
      rsum_c = rsum_c + 20'($signed(f0_r[k]));
    end
    mx_c = 19'($signed(f0_r[1])) - 19'($signed(f0_r[3])) + 19'($signed(f0_r[5]))
         - 19'($signed(f0_r[6])) - 19'($signed(f0_r[7])) + 19'($signed(f0_r[8]));
    my_c = 19'($signed(f0_r[2])) - 19'($signed(f0_r[4])) + 19'($signed(f0_r[5]))
         + 19'($signed(f0_r[6])) - 19'($signed(f0_r[7])) - 19'($signed(f0_r[8]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r    <= f0_r;
      mask1_r <= mask0_r;
      edge1_r <= edge0_r;
      rsum1_r <= rsum_c;
      mx1_r   <= mx_c;
      my1_r   <= my_c;
    end
  end

  // Stage 2: magnitudes and signs for the divider, saturated density.
  logic        v2_r;
  side_t       side2_r;
  logic [18:0] den2_r;
  logic [17:0] nx2_r, ny2_r;
  logic [19:0] rabs_c;
  logic [18:0] xabs_c, yabs_c;
  logic [15:0] rsat_c;

  always_comb begin
    rabs_c = rsum1_r[19] ? 20'(-rsum1_r) : 20'(rsum1_r);
    xabs_c = mx1_r[18] ? 19'(-mx1_r) : 19'(mx1_r);
    yabs_c = my1_r[18] ? 19'(-my1_r) : 19'(my1_r);
    if (rsum1_r > 20'sd32767) begin
      rsat_c = 16'h7fff;
    end else if (rsum1_r < -20'sd32768) begin
      rsat_c = 16'h8000;
    end else begin
      rsat_c = rsum1_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den2_r           <= rabs_c[18:0];
      nx2_r            <= xabs_c[17:0];
      ny2_r            <= yabs_c[17:0];
      side2_r.mask     <= mask1_r;
      side2_r.at_edge  <= edge1_r;
      side2_r.neg_x    <= mx1_r[18] ^ rsum1_r[19];
      side2_r.neg_y    <= my1_r[18] ^ rsum1_r[19];
      side2_r.zero_rho <= (rsum1_r == 20'sd0);
      side2_r.rho      <= rsat_c;
      side2_r.dirs     <= f1_r;
    end
  end

  // Velocity dividers, with the rest of the cell delayed beside them.
  logic [DIV_QBITS-1:0] qx, qy;
  logic                 ovx, ovy;

  lbc_div u_div_x (
    .clk   (clk),
    .en    (en),
    .num_i (nx2_r),
    .den_i (den2_r),
    .quo_o (qx),
    .ovf_o (ovx)
  );

  lbc_div u_div_y (
    .clk   (clk),
    .en    (en),
    .num_i (ny2_r),
    .den_i (den2_r),
    .quo_o (qy),
    .ovf_o (ovy)
  );

  side_t sdl_r [0:DIV_LAT-1];
  logic  vdl_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        vdl_r[i] <= 1'b0;
      end
    end else if (en) begin
      vdl_r[0] <= v2_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        vdl_r[i] <= vdl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sdl_r[0] <= side2_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        sdl_r[i] <= sdl_r[i-1];
      end
    end
  end

  // Signed, saturated velocity from the quotient magnitude.
  function automatic logic [15:0] vel_sat(input logic [DIV_QBITS-1:0] q, input logic ovf,
                                          input logic neg, input logic zero);
    logic [15:0] res;
    if (zero) begin
      res = 16'h0000;
    end else if (neg) begin
      res = (ovf || q[DIV_QBITS-1:15] != '0) ? 16'h8000 : 16'(-q[15:0]);
    end else begin
      res = (ovf || q[DIV_QBITS-1:15] != '0) ? 16'h7fff : q[15:0];
    end
    return res;
  endfunction

  // Stage 3: pick measured or imposed cell state.
  side_t       sd;
  logic        cv_r;
  logic [8:0][15:0] cf_r;
  logic [8:0]  cmask_r;
  q14_t        crho_r, cux_r, cuy_r;
  logic [14:0] com_r;

  assign sd = sdl_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else if (en) begin
      cv_r <= vdl_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cf_r    <= sd.dirs;
      cmask_r <= sd.mask;
      if (sd.at_edge) begin
        crho_r <= {1'b0, edge_rho_r};
        cux_r  <= edge_ux_r;
        cuy_r  <= edge_uy_r;
        com_r  <= edge_relax_r;
      end else begin
        crho_r <= sd.rho;
        cux_r  <= vel_sat(qx, ovx, sd.neg_x, sd.zero_rho);
        cuy_r  <= vel_sat(qy, ovy, sd.neg_y, sd.zero_rho);
        com_r  <= relax_r;
      end
    end
  end

  // Shared u.u, timed to meet the second stage of every lane.
  logic signed [31:0] uxx_r, uyy_r;
  logic [31:0]        usq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      uxx_r <= cux_r * cux_r;
      uyy_r <= cuy_r * cuy_r;
      usq_r <= 32'(uxx_r) + 32'(uyy_r);
    end
  end

  // Nine direction lanes.
  logic [8:0][15:0] post;

  for (genvar k = 0; k < NDIR; k++) begin : g_lane
    lbc_lane #(
      .EX (DIR_EX[k]),
      .EY (DIR_EY[k]),
      .W  (DIR_W36[k])
    ) u_lane (
      .clk     (clk),
      .en      (en),
      .f_i     (cf_r[k]),
      .rho_i   (crho_r),
      .ux_i    (cux_r),
      .uy_i    (cuy_r),
      .omega_i (com_r),
      .usq_i   (usq_r),
      .post_o  (post[k])
    );
  end

  // Cell data delayed to match the lanes.
  logic        lv_r    [0:LANE_LAT-1];
  logic [8:0]  lmask_r [0:LANE_LAT-1];
  logic [15:0] lrho_r  [0:LANE_LAT-1];
  logic [15:0] lux_r   [0:LANE_LAT-1];
  logic [15:0] luy_r   [0:LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        lv_r[i] <= 1'b0;
      end
    end else if (en) begin
      lv_r[0] <= cv_r;
      for (int i = 1; i < LANE_LAT; i++) begin
        lv_r[i] <= lv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lmask_r[0] <= cmask_r;
      lrho_r[0]  <= crho_r;
      lux_r[0]   <= cux_r;
      luy_r[0]   <= cuy_r;
      for (int i = 1; i < LANE_LAT; i++) begin
        lmask_r[i] <= lmask_r[i-1];
        lrho_r[i]  <= lrho_r[i-1];
        lux_r[i]   <= lux_r[i-1];
        luy_r[i]   <= luy_r[i-1];
      end
    end
  end

  // Bounce-back merge and output buffering.
  res_t res;

  lbc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .tail_valid (lv_r[LANE_LAT-1]),
    .post_i     (post),
    .mask_i     (lmask_r[LANE_LAT-1]),
    .rho_i      (lrho_r[LANE_LAT-1]),
    .ux_i       (lux_r[LANE_LAT-1]),
    .uy_i       (luy_r[LANE_LAT-1]),
    .out_ready  (out_ready),
    .en         (en),
    .out_valid  (out_valid),
    .res_o      (res)
  );

  assign in_ready            = en;
  assign out_rest            = res.dirs[0];
  assign out_east            = res.dirs[1];
  assign out_north           = res.dirs[2];
  assign out_west            = res.dirs[3];
  assign out_south           = res.dirs[4];
  assign out_northeast       = res.dirs[5];
  assign out_northwest       = res.dirs[6];
  assign out_southwest       = res.dirs[7];
  assign out_southeast       = res.dirs[8];
  assign out_cell_density    = res.rho;
  assign out_cell_velocity_x = res.ux;
  assign out_cell_velocity_y = res.uy;
endmodule

### hw/rtl/lbc_checker.sv
`timescale 1ns / 1ps
module lbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_rest,
  input logic [15:0] out_cell_density
);

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // The input side only stalls while a result is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with no pending result");

  a_stall_start: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("in_ready fell without a stalled result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rest) && $stable(out_cell_density))
    else $error("stalled result changed");

endmodule

bind lattice_boltzmann_cell_collision_core lbc_checker u_lbc_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the D2Q9 BGK cell collision core.
//
// Every fluid cell the core accepts is run through a local model of the collision
// (density and momentum sums, the velocity divide, the equilibrium, the
// relaxation and the bounce-back remap). Fluid cells queue the expected
// result. Obstacle cells queue nothing. A checker compares every output
// transfer, field by field, against the oldest queued result.
//
// The run has these parts, each in its own task:
//   - a directed set of corner cells,
//   - a sweep over register settings, the extremes among them,
//   - random traffic under four idling mixes,
//   - a long receiver hold-off while the sender keeps offering cells.
// Registers are only written once the core has drained. An obstacle cell may
// still be in flight when the queue runs empty, so every drain waits a further
// margin.
module tb_top;
  import lbc_pkg::*;

  localparam int  DRAIN_MARGIN = 48;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [8:0][15:0] d;
    logic [8:0]       mask;
    logic             at_edge;
    logic             fluid;
  } cell_t;

  typedef logic [11:0][15:0] cell_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic          in_valid = 1'b0;
  logic          in_ready;
  q14_t          in_dist [NDIR];
  logic [8:0]    in_obstacle_mask = '0;
  logic          in_at_edge = 1'b0;
  logic          in_cell_is_fluid = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  q14_t          out_dist [NDIR];
  q14_t          out_cell_density;
  q14_t          out_cell_velocity_x;
  q14_t          out_cell_velocity_y;
  logic          cfg_we = 1'b0;
  cfg_idx_t      cfg_index = CFG_RELAX;
  logic [15:0]   cfg_wdata = '0;

  initial begin
    for (int k = 0; k < NDIR; k++) in_dist[k] = '0;
  end

  lattice_boltzmann_cell_collision_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_dist_rest        (in_dist[0]),
    .in_dist_east        (in_dist[1]),
    .in_dist_north       (in_dist[2]),
    .in_dist_west        (in_dist[3]),
    .in_dist_south       (in_dist[4]),
    .in_dist_northeast   (in_dist[5]),
    .in_dist_northwest   (in_dist[6]),
    .in_dist_southwest   (in_dist[7]),
    .in_dist_southeast   (in_dist[8]),
    .in_obstacle_mask    (in_obstacle_mask),
    .in_at_edge          (in_at_edge),
    .in_cell_is_fluid    (in_cell_is_fluid),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_rest            (out_dist[0]),
    .out_east            (out_dist[1]),
    .out_north           (out_dist[2]),
    .out_west            (out_dist[3]),
    .out_south           (out_dist[4]),
    .out_northeast       (out_dist[5]),
    .out_northwest       (out_dist[6]),
    .out_southwest       (out_dist[7]),
    .out_southeast       (out_dist[8]),
    .out_cell_density    (out_cell_density),
    .out_cell_velocity_x (out_cell_velocity_x),
    .out_cell_velocity_y (out_cell_velocity_y),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the configuration, loaded with the reset defaults.
  longint omega_int = 31949;
  longint omega_edge = 16384;
  longint rho_edge = 16384;
  longint ux_edge = 819;
  longint uy_edge = 0;

  cell_out_t pending_cells [$];
  int        errors = 0;
  longint    cycle_count = 0;

  // Idling percentages for the sender and receiver.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // The receiver hold-off is requested by bumping hold_req; the receiver
  // process notices the change and counts the stretch down itself.
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Run limit. Reaching it means the core hung or lost results.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // Rounds to nearest with ties toward plus infinity, d positive.
  function automatic longint round_quot(longint n, longint d);
    return floor_quot(n + d / 2, d);
  endfunction

  function automatic longint clamp16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  // Collision of one fluid cell, returning the remapped post-collision values
  // followed by the density and velocity that were used.
  function automatic cell_out_t collide(cell_t c);
    longint f [NDIR];
    longint post [NDIR];
    longint rsum, mx, my, rho, ux, uy, om, usq, eu, p2, feq, rel;
    cell_out_t r;
    rsum = 0;
    mx = 0;
    my = 0;
    for (int k = 0; k < NDIR; k++) begin
      f[k] = longint'($signed(c.d[k]));
      rsum += f[k];
      mx += f[k] * DIR_EX[k];
      my += f[k] * DIR_EY[k];
    end
    if (c.at_edge) begin
      rho = rho_edge;
      ux = ux_edge;
      uy = uy_edge;
      om = omega_edge;
    end else begin
      // A zero density sum yields zero velocity instead of a divide.
      if (rsum != 0) begin
        ux = clamp16((mx * 16384) / rsum);
        uy = clamp16((my * 16384) / rsum);
      end else begin
        ux = 0;
        uy = 0;
      end
      rho = clamp16(rsum);
      om = omega_int;
    end
    usq = ux * ux + uy * uy;
    for (int k = 0; k < NDIR; k++) begin
      eu = ux * DIR_EX[k] + uy * DIR_EY[k];
      p2 = (longint'(2) << 28) - 3 * usq + 6 * eu * 16384 + 9 * eu * eu;
      feq = round_quot(DIR_W36[k] * rho * p2, longint'(72) << 28);
      rel = round_quot(om * (feq - f[k]), 16384);
      post[k] = clamp16(f[k] + rel);
    end
    // Bounce-back: a reflected value takes priority over the streamed one.
    for (int k = 0; k < NDIR; k++) begin
      r[k] = c.mask[DIR_INV[k]] ? post[DIR_INV[k]][15:0] : post[k][15:0];
    end
    r[9] = rho[15:0];
    r[10] = ux[15:0];
    r[11] = uy[15:0];
    return r;
  endfunction

  task automatic report(string what, int field, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s field %0d: got %0d expected %0d", what, field,
             $signed(got), $signed(want));
    errors++;
  endtask

  // Result checker. Samples at the edge, so it sees pre-edge values.
  always @(posedge clk) begin
    cell_out_t got, want;
    if (rst_n && out_valid && out_ready) begin
      for (int k = 0; k < NDIR; k++) got[k] = out_dist[k];
      got[9] = out_cell_density;
      got[10] = out_cell_velocity_x;
      got[11] = out_cell_velocity_y;
      if (pending_cells.size() == 0) begin
        report("unexpected result", 0, got[0], 16'h0);
      end else begin
        want = pending_cells.pop_front();
        for (int k = 0; k < 12; k++) begin
          if (got[k] !== want[k]) report("result", k, got[k], want[k]);
        end
      end
    end
  end

  // Offers one cell, after a random gap, and returns once it is transferred.
  // in_valid is only lowered when a gap follows, so a back-to-back cell never
  // sees it dropped and raised in the same step.
  task automatic send_cell(cell_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int k = 0; k < NDIR; k++) in_dist[k] <= c.d[k];
    in_obstacle_mask <= c.mask;
    in_at_edge <= c.at_edge;
    in_cell_is_fluid <= c.fluid;
    do @(posedge clk); while (!in_ready);
    if (c.fluid) pending_cells.push_back(collide(c));
  endtask

  // Stops offering and waits until the core holds nothing.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_MARGIN) @(posedge clk);
  endtask

  // Drives one register write; the caller lowers cfg_we after the last one,
  // so back-to-back writes never assign it twice in one step.
  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_RELAX:      omega_int = longint'(value[14:0]);
      CFG_EDGE_RELAX: omega_edge = longint'(value[14:0]);
      CFG_EDGE_RHO:   rho_edge = longint'(value[14:0]);
      CFG_EDGE_UX:    ux_edge = longint'($signed(value));
      CFG_EDGE_UY:    uy_edge = longint'($signed(value));
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] om, logic [15:0] ome, logic [15:0] rho,
                           logic [15:0] ux, logic [15:0] uy);
    write_reg(CFG_RELAX, om);
    write_reg(CFG_EDGE_RELAX, ome);
    write_reg(CFG_EDGE_RHO, rho);
    write_reg(CFG_EDGE_UX, ux);
    write_reg(CFG_EDGE_UY, uy);
    cfg_we <= 1'b0;
  endtask

  // Random cell. Most are near-equilibrium fluid cells with small noise, so
  // the velocity and relaxation stay in a physical range; the rest are raw
  // 16-bit noise that exercises saturation and every input bit.
  function automatic cell_t random_cell();
    cell_t c;
    int rho, noise;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(cell_t)-1:0];
    if ($urandom_range(99) < 75) begin
      rho = $urandom_range(8000, 24000);
      noise = $urandom_range(1, 1200);
      for (int k = 0; k < NDIR; k++) begin
        c.d[k] = 16'(rho * DIR_W36[k] / 36 + $signed($urandom_range(2 * noise)) - noise);
      end
      c.mask = ($urandom_range(3) == 0) ? 9'(1 << $urandom_range(8)) :
               (($urandom_range(3) == 0) ? 9'($urandom) : 9'h0);
      c.at_edge = ($urandom_range(4) == 0);
      c.fluid = ($urandom_range(9) != 0);
    end
    return c;
  endfunction

  function automatic cell_t make_cell(logic [15:0] v, logic [8:0] mask,
                                      logic at_edge, logic fluid);
    cell_t c;
    for (int k = 0; k < NDIR; k++) c.d[k] = v;
    c.mask = mask;
    c.at_edge = at_edge;
    c.fluid = fluid;
    return c;
  endfunction

  task automatic test_directed();
    cell_t c;
    send_cell(make_cell(16'h0000, 9'h000, 1'b0, 1'b1));
    send_cell(make_cell(16'h7fff, 9'h000, 1'b0, 1'b1));
    send_cell(make_cell(16'h8000, 9'h000, 1'b0, 1'b1));
    send_cell(make_cell(16'h7fff, 9'h1ff, 1'b1, 1'b1));
    send_cell(make_cell(16'h8000, 9'h1ff, 1'b0, 1'b1));
    // Obstacle cells carry arbitrary flags and must produce nothing.
    send_cell(make_cell(16'h1234, 9'h1ff, 1'b1, 1'b0));
    send_cell(make_cell(16'h0000, 9'h000, 1'b0, 1'b0));
    // Density sum of zero with nonzero momentum.
    c = make_cell(16'h0000, 9'h000, 1'b0, 1'b1);
    c.d[1] = 16'sd3000;
    c.d[3] = -16'sd3000;
    c.d[5] = 16'sd500;
    c.d[7] = -16'sd500;
    send_cell(c);
    // A rest cell at unit density, then the same with a single east flow.
    c = make_cell(16'd455, 9'h000, 1'b0, 1'b1);
    for (int k = 1; k < 5; k++) c.d[k] = 16'd1820;
    c.d[0] = 16'd7282;
    send_cell(c);
    c.d[1] = 16'd5000;
    send_cell(c);
    // Tiny density with large momentum saturates the velocity.
    c = make_cell(16'h0000, 9'h000, 1'b0, 1'b1);
    c.d[1] = 16'sd20000;
    c.d[3] = -16'sd19999;
    c.d[2] = 16'sd30000;
    c.d[4] = -16'sd30000;
    c.d[6] = 16'sd1;
    send_cell(c);
    c.d[0] = 16'sd1;
    c.d[6] = -16'sd2;
    send_cell(c);
    // The rest bit alone has no effect; then each direction bit on its own.
    c = make_cell(16'd455, 9'h001, 1'b0, 1'b1);
    c.d[0] = 16'd7000;
    c.d[1] = 16'd2600;
    c.d[6] = 16'd900;
    send_cell(c);
    for (int k = 1; k < NDIR; k++) begin
      c.mask = 9'(1 << k);
      c.at_edge = k[0];
      send_cell(c);
    end
    drain();
  endtask

  task automatic test_config_sweep();
    logic [15:0] set [6][5];
    set[0] = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
    set[1] = '{16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000};
    set[2] = '{16'hffff, 16'h8001, 16'h4000, 16'h8000, 16'h7fff};
    set[3] = '{16'h2000, 16'h6000, 16'h7fff, 16'h0000, 16'hfccd};
    set[4] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    set[5] = '{16'd31949, 16'd16384, 16'd16384, 16'd819, 16'd0};
    for (int s = 0; s < 6; s++) begin
      write_all(set[s][0], set[s][1], set[s][2], set[s][3], set[s][4]);
      for (int i = 0; i < 30; i++) send_cell(random_cell());
      drain();
    end
  endtask

  task automatic test_random_idling();
    int mix [4][2];
    mix = '{'{0, 0}, '{60, 0}, '{0, 60}, '{34, 34}};
    for (int m = 0; m < 4; m++) begin
      send_idle_pct = mix[m][0];
      recv_stall_pct = mix[m][1];
      for (int i = 0; i < 120; i++) send_cell(random_cell());
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // The receiver holds off long enough for the core to fill and drop
  // in_ready while cells keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req++;
    for (int i = 0; i < 120; i++) send_cell(random_cell());
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_random_idling();
    test_backpressure();
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
